/* hdl/ffp_pkg.sv */
// Package for the orthonormal frame pipeline: widths, latencies, status codes,
// root and divide per-step functions and a bit-length helper. No dependencies.
package ffp_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int WIDE_W    = 67;
  localparam int Q30_W     = 32;
  localparam int S_W       = 30;

  localparam int ISQRT_LAT = 17;
  localparam int DIV_LAT   = 16;
  localparam int UNIT_LAT  = 42;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [Q30_W-1:0]   q30_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NORMAL_ZERO = 2'd1,
    ST_XAXIS_ZERO  = 2'd2,
    ST_YAXIS_ZERO  = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] den;
    logic [31:0] q;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t a, input logic [63:0] b);
    sq_t         res;
    logic [63:0] t;
    t = a.r + b;
    if (a.x >= t) begin
      res.x = a.x - t;
      res.r = (a.r >> 1) + b;
    end else begin
      res.x = a.x;
      res.r = a.r >> 1;
    end
    return res;
  endfunction

  function automatic dv_t div_step(input dv_t a);
    dv_t         res;
    logic [32:0] t;
    logic [32:0] t2;
    logic        qb;
    t  = {a.rem, a.low[31]};
    t2 = t - {1'b0, a.den};
    qb = (t >= {1'b0, a.den});
    res.rem = qb ? t2[31:0] : t[31:0];
    res.low = a.low << 1;
    res.den = a.den;
    res.q   = {a.q[30:0], qb};
    return res;
  endfunction

  function automatic logic [5:0] bitlen34(input logic [33:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 34; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

endpackage

/* hdl/ffp_isqrt.sv */
// Pipelined rounded integer square root, two result bits per stage.
// Depends on ffp_pkg.
module ffp_isqrt import ffp_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] s_i,
  output logic [31:0] l_o
);

  localparam int STAGES = ISQRT_LAT - 1;

  sq_t         st_q [STAGES];
  sq_t         st_d [STAGES];
  logic [31:0] l_q;

  always_comb begin
    sq_t a;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        a.x = s_i;
        a.r = '0;
      end else begin
        a = st_q[k-1];
      end
      st_d[k] = sqrt_step(sqrt_step(a, 64'd1 << (62 - 4 * k)), 64'd1 << (60 - 4 * k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < STAGES; k++) st_q[k] <= st_d[k];
      l_q <= st_q[STAGES-1].r[31:0] + {31'b0, (st_q[STAGES-1].x > st_q[STAGES-1].r)};
    end
  end

  assign l_o = l_q;

endmodule

/* hdl/ffp_div.sv */
// Pipelined restoring divider, 32-bit quotient, two quotient bits per stage.
// Depends on ffp_pkg.
module ffp_div import ffp_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [31:0] q_o
);

  localparam int STAGES = DIV_LAT;

  dv_t st_q [STAGES];
  dv_t st_d [STAGES];

  always_comb begin
    dv_t a;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        a.rem = num_i[63:32];
        a.low = num_i[31:0];
        a.den = den_i;
        a.q   = '0;
      end else begin
        a = st_q[k-1];
      end
      st_d[k] = div_step(div_step(a));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < STAGES; k++) st_q[k] <= st_d[k];
    end
  end

  assign q_o = st_q[STAGES-1].q;

endmodule

/* hdl/ffp_unit3.sv */
// Pipelined normalizer of a 3-vector to Q2.30 unit length, with nonzero flag.
// Depends on ffp_pkg, ffp_isqrt, ffp_div.
module ffp_unit3 import ffp_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  wide_t v_i [3],
  output q30_t  u_o [3],
  output logic  nz_o
);

  localparam int NEG_LEN = 41;
  localparam int NZ_LEN  = 38;
  localparam int S_LEN   = 20;

  logic [WIDE_W-1:0] m1_q [3];
  logic [WIDE_W-1:0] m2_q [3];
  logic [WIDE_W-1:0] m3_q [3];
  logic [WIDE_W-1:0] m4_q [3];
  logic [WIDE_W-1:0] or_q;
  logic [5:0]        blhi_q, bllo_q;
  logic              right_q;
  logic [5:0]        amt_q;
  logic [6:0]        n_d;
  logic [S_W-1:0]    s_q [S_LEN][3];
  logic [59:0]       sq_q [3];
  logic [63:0]       sum_q;
  logic [31:0]       len;
  logic [63:0]       num_q [3];
  logic [31:0]       den_q;
  logic [31:0]       quo [3];
  logic              neg_q [NEG_LEN][3];
  logic              nz_q [NZ_LEN];
  q30_t              u_q [3];
  logic              nzo_q;

  assign n_d = (blhi_q != '0) ? 7'd33 + {1'b0, blhi_q} : {1'b0, bllo_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m1_q[i]      <= v_i[i][WIDE_W-1] ? WIDE_W'(0) - v_i[i] : v_i[i];
        neg_q[0][i]  <= v_i[i][WIDE_W-1];
        m2_q[i]      <= m1_q[i];
        m3_q[i]      <= m2_q[i];
        m4_q[i]      <= m3_q[i];
        s_q[0][i]    <= right_q ? S_W'(m4_q[i] >> amt_q) : S_W'(m4_q[i] << amt_q);
        sq_q[i]      <= s_q[0][i] * s_q[0][i];
        num_q[i]     <= {4'b0, s_q[S_LEN-1][i], 30'b0} + {33'b0, len[31:1]};
      end
      or_q    <= m1_q[0] | m1_q[1] | m1_q[2];
      blhi_q  <= bitlen34(or_q[66:33]);
      bllo_q  <= bitlen34({1'b0, or_q[32:0]});
      right_q <= (n_d > 7'd30);
      amt_q   <= (n_d > 7'd30) ? 6'(n_d - 7'd30) : 6'(7'd30 - n_d);
      nz_q[0] <= (n_d != '0);
      sum_q   <= {4'b0, sq_q[0]} + {4'b0, sq_q[1]} + {4'b0, sq_q[2]};
      den_q   <= len;
      for (int j = 1; j < NEG_LEN; j++) neg_q[j] <= neg_q[j-1];
      for (int j = 1; j < NZ_LEN; j++) nz_q[j] <= nz_q[j-1];
      for (int j = 1; j < S_LEN; j++) s_q[j] <= s_q[j-1];
      for (int i = 0; i < 3; i++) begin
        if (quo[i] > Q30_ONE) begin
          u_q[i] <= neg_q[NEG_LEN-1][i] ? q30_t'(32'd0 - Q30_ONE) : q30_t'(Q30_ONE);
        end else begin
          u_q[i] <= neg_q[NEG_LEN-1][i] ? q30_t'(32'd0 - quo[i]) : q30_t'(quo[i]);
        end
      end
      nzo_q <= nz_q[NZ_LEN-1];
    end
  end

  ffp_isqrt u_isqrt (
    .clk_i (clk_i),
    .en_i  (en_i),
    .s_i   (sum_q),
    .l_o   (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    ffp_div u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (num_q[i]),
      .den_i (den_q),
      .q_o   (quo[i])
    );
  end

  assign u_o  = u_q;
  assign nz_o = nzo_q;

endmodule

/* hdl/frame_from_three_points.sv */
// Orthonormal frame from three points: X, Y, Z unit rows in Q2.30 plus status.
// Input to result: 89 pipeline stages plus the output register. One
// transaction per cycle is sustained while the output is not stalled; the
// root and divide units are fully pipelined. A stalled output freezes the
// whole pipeline unless its last stage is empty. Reset clears all valid bits.
module frame_from_three_points import ffp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z (32 bits each)
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row_x_x/y/z, row_y_x/y/z, row_z_x/y/z (32 bits each), status (2), pad (6)
  output logic [295:0] m_axis_tdata
);

  localparam int Z_OUT    = 3 + UNIT_LAT;
  localparam int Y_OUT    = Z_OUT + 2 + UNIT_LAT;
  localparam int ROW_DLY  = Y_OUT - Z_OUT;

  logic        en;
  logic        vld_q [Y_OUT];
  logic        ovld_q;
  logic [295:0] odata_q;
  logic [295:0] odata_d;

  coord_t      p [9];
  diff_t       d1_q [3], e1_q [3], d2_q [3], d3_q [3];
  logic signed [65:0] pa_q [3], pb_q [3];
  wide_t       cr_q [3], xv [3], yv_q [3];
  q30_t        rz, rx;
  q30_t        rz_u [3], rx_u [3], ry_u [3];
  logic        nzz, nzx, nzy;
  logic signed [63:0] ya_q [3], yb_q [3];
  q30_t        rzd_q [ROW_DLY][3];
  q30_t        rxd_q [ROW_DLY][3];
  logic        nzzd_q [ROW_DLY];
  logic        nzxd_q [ROW_DLY];
  status_e     status;

  assign en = !vld_q[Y_OUT-1] || !ovld_q || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign p[i] = s_axis_tdata[32*i +: 32];
  end

  for (genvar i = 0; i < 3; i++) begin : g_xin
    assign xv[i] = WIDE_W'(d3_q[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < Y_OUT; j++) vld_q[j] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int j = 1; j < Y_OUT; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= DIFF_W'(p[3+i]) - DIFF_W'(p[i]);
        e1_q[i] <= DIFF_W'(p[6+i]) - DIFF_W'(p[i]);
        d2_q[i] <= d1_q[i];
        d3_q[i] <= d2_q[i];
        pa_q[i] <= d1_q[(i+1)%3] * e1_q[(i+2)%3];
        pb_q[i] <= d1_q[(i+2)%3] * e1_q[(i+1)%3];
        cr_q[i] <= WIDE_W'(pa_q[i]) - WIDE_W'(pb_q[i]);
        ya_q[i] <= rz_u[(i+1)%3] * rx_u[(i+2)%3];
        yb_q[i] <= rz_u[(i+2)%3] * rx_u[(i+1)%3];
        yv_q[i] <= WIDE_W'(ya_q[i]) - WIDE_W'(yb_q[i]);
      end
      rzd_q[0]  <= rz_u;
      rxd_q[0]  <= rx_u;
      nzzd_q[0] <= nzz;
      nzxd_q[0] <= nzx;
      for (int j = 1; j < ROW_DLY; j++) begin
        rzd_q[j]  <= rzd_q[j-1];
        rxd_q[j]  <= rxd_q[j-1];
        nzzd_q[j] <= nzzd_q[j-1];
        nzxd_q[j] <= nzxd_q[j-1];
      end
    end
  end

  ffp_unit3 u_unit_z (.clk_i(clk_i), .en_i(en), .v_i(cr_q), .u_o(rz_u), .nz_o(nzz));
  ffp_unit3 u_unit_x (.clk_i(clk_i), .en_i(en), .v_i(xv),   .u_o(rx_u), .nz_o(nzx));
  ffp_unit3 u_unit_y (.clk_i(clk_i), .en_i(en), .v_i(yv_q), .u_o(ry_u), .nz_o(nzy));

  always_comb begin
    if (!nzzd_q[ROW_DLY-1]) begin
      status = ST_NORMAL_ZERO;
    end else if (!nzxd_q[ROW_DLY-1]) begin
      status = ST_XAXIS_ZERO;
    end else if (!nzy) begin
      status = ST_YAXIS_ZERO;
    end else begin
      status = ST_OK;
    end
  end

  assign rz = rzd_q[ROW_DLY-1][0];
  assign rx = rxd_q[ROW_DLY-1][0];

  always_comb begin
    odata_d = '0;
    odata_d[289:288] = status;
    if (status == ST_OK) begin
      odata_d[31:0] = rx;
      for (int i = 1; i < 3; i++) begin
        odata_d[32*i +: 32] = rxd_q[ROW_DLY-1][i];
      end
      for (int i = 0; i < 3; i++) begin
        odata_d[32*(3+i) +: 32] = ry_u[i];
      end
      odata_d[32*6 +: 32] = rz;
      for (int i = 1; i < 3; i++) begin
        odata_d[32*(6+i) +: 32] = rzd_q[ROW_DLY-1][i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (!ovld_q || m_axis_tready) begin
      ovld_q <= vld_q[Y_OUT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ovld_q || m_axis_tready) begin
      odata_q <= odata_d;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[289:288] != ST_OK) |-> m_axis_tdata[287:0] == '0)
    else $error("failed frame carries nonzero matrix");

  a_no_xzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[289:288] != ST_XAXIS_ZERO)
    else $error("x axis zero without zero normal");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && vld_q[Y_OUT-1] |-> !s_axis_tready)
    else $error("pipeline advanced into a stalled output");

endmodule
